// File: rtl/lprt_pkg.sv
// ----------------------------------------------------------------------------
// Longest-prefix route table package
// Shared types and constants for the route table cells and the top level.
// ----------------------------------------------------------------------------
package lprt_pkg;

   localparam int ROUTE_W    = 32;
   localparam int ACTION_W   = 2;
   localparam int STATUS_W   = 2;
   localparam int OUT_COUNT_W = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_ADD    = 2'd1,
      ACT_FLUSH  = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_MISS    = 2'd1,
      ST_PRESENT = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_SCAN,
      CS_INSERT,
      CS_RESP
   } ctrl_state_type;

   // Command broadcast to every cell while a transaction is in progress.
   typedef struct packed {
      logic               is_add;
      logic               insert;
      logic [ROUTE_W-1:0] addr;
      logic [ROUTE_W-1:0] net;
      logic [ROUTE_W-1:0] mask;
   } cmd_type;

   // Search token handed from cell to cell, one cell per cycle.
   typedef struct packed {
      logic               active;
      logic               hit;
      logic [ROUTE_W-1:0] net;
      logic [ROUTE_W-1:0] mask;
   } tok_type;

endpackage

// File: rtl/longest_prefix_route_table.sv
// ----------------------------------------------------------------------------
// Longest-prefix route table
// IPv4 route table kept in order of descending mask, built as a row of cells
// that each hold one route. Lookups return the longest matching prefix; adds
// insert in mask order after a duplicate check; a flush empties the table.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_ready  action, lookup_address,
//                                              route_net, route_mask
//   rsp_     out        rsp_valid / rsp_ready  status, matched_net,
//                                              matched_mask, entry_count
//
// A lookup or an add sends a search token down the row of cells, one cell per
// cycle, so the walk over the table sets how long the block stays busy; an
// add that inserts then passes through the insertion state, and a flush or an
// unused action code skips the walk and goes straight to the response.
// Reset empties the table at once by clearing the route count; the route
// storage itself needs no clearing pass, since only entries below the count
// are ever consulted.
// The result sits in an output register, so a new request transaction is
// taken while the previous response transaction is still stalled; the new
// result then waits in the controller until the output register frees up.
// ----------------------------------------------------------------------------
module longest_prefix_route_table
   import lprt_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [ROUTE_W-1:0]     req_lookup_address,
   input  logic [ROUTE_W-1:0]     req_route_net,
   input  logic [ROUTE_W-1:0]     req_route_mask,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [ROUTE_W-1:0]     rsp_matched_net,
   output logic [ROUTE_W-1:0]     rsp_matched_mask,
   output logic [OUT_COUNT_W-1:0] rsp_entry_count
);

   localparam int CNT_W = $clog2(TABLE_DEPTH+1);

   // Control state.
   ctrl_state_type         state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   start_ff, start_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Held request and pending result.
   logic [ACTION_W-1:0]    act_ff, act_in;
   logic [ROUTE_W-1:0]     addr_ff, addr_in;
   logic [ROUTE_W-1:0]     net_ff, net_in;
   logic [ROUTE_W-1:0]     mask_ff, mask_in;
   status_type             res_status_ff, res_status_in;
   logic [ROUTE_W-1:0]     res_net_ff, res_net_in;
   logic [ROUTE_W-1:0]     res_mask_ff, res_mask_in;

   // Output register.
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [ROUTE_W-1:0]     rsp_net_ff, rsp_net_in;
   logic [ROUTE_W-1:0]     rsp_mask_ff, rsp_mask_in;
   logic [OUT_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                   accept;
   cmd_type                cmd;
   tok_type                tok_chain [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0] ge_vec;
   logic [ROUTE_W-1:0]     ent_net  [TABLE_DEPTH];
   logic [ROUTE_W-1:0]     ent_mask [TABLE_DEPTH];
   tok_type                tok_end;

   assign req_ready = (state_ff == CS_IDLE);
   assign accept    = req_valid & req_ready;

   // The command is broadcast to every cell; the insert strobe lasts one cycle.
   assign cmd.is_add = (act_ff == ACT_ADD);
   assign cmd.insert = (state_ff == CS_INSERT);
   assign cmd.addr   = addr_ff;
   assign cmd.net    = net_ff;
   assign cmd.mask   = mask_ff;

   // The token enters the first cell for one cycle when a search starts.
   assign tok_chain[0] = '{active: start_ff, hit: 1'b0, net: '0, mask: '0};
   assign tok_end      = tok_chain[TABLE_DEPTH];

   // Row of cells. Each cell sees its upstream neighbour's route and shift
   // flag, so an insertion moves every later route down by one place, all in
   // the same cycle.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic               prev_ge;
      logic [ROUTE_W-1:0] prev_net;
      logic [ROUTE_W-1:0] prev_mask;

      if (i == 0) begin : g_first
         assign prev_ge   = 1'b0;
         assign prev_net  = net_ff;
         assign prev_mask = mask_ff;
      end else begin : g_rest
         assign prev_ge   = ge_vec[i-1];
         assign prev_net  = ent_net[i-1];
         assign prev_mask = ent_mask[i-1];
      end

      lprt_cell #(
         .DEPTH (TABLE_DEPTH),
         .IDX   (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .count_i   (count_ff),
         .cmd       (cmd),
         .tok_in    (tok_chain[i]),
         .tok_out   (tok_chain[i+1]),
         .prev_ge   (prev_ge),
         .prev_net  (prev_net),
         .prev_mask (prev_mask),
         .ge_out    (ge_vec[i]),
         .net_out   (ent_net[i]),
         .mask_out  (ent_mask[i])
      );
   end

   // Controller. A search finishes when the token drops out of the last cell;
   // an add that found no duplicate and has room then passes through the
   // insertion state. The result is held until the output register is free.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      start_in      = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      act_in        = act_ff;
      addr_in       = addr_ff;
      net_in        = net_ff;
      mask_in       = mask_ff;
      res_status_in = res_status_ff;
      res_net_in    = res_net_ff;
      res_mask_in   = res_mask_ff;
      rsp_status_in = rsp_status_ff;
      rsp_net_in    = rsp_net_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_count_in  = rsp_count_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         CS_IDLE: begin
            if (accept) begin
               act_in  = req_action;
               addr_in = req_lookup_address;
               net_in  = req_route_net;
               mask_in = req_route_mask;
               case (req_action)
                  ACT_LOOKUP, ACT_ADD: begin
                     start_in = 1'b1;
                     state_in = CS_SCAN;
                  end
                  ACT_FLUSH: begin
                     count_in      = '0;
                     res_status_in = ST_OK;
                     res_net_in    = '0;
                     res_mask_in   = '0;
                     state_in      = CS_RESP;
                  end
                  default: begin
                     res_status_in = ST_MISS;
                     res_net_in    = '0;
                     res_mask_in   = '0;
                     state_in      = CS_RESP;
                  end
               endcase
            end
         end
         CS_SCAN: begin
            if (tok_end.active) begin
               state_in = CS_RESP;
               if (act_ff == ACT_LOOKUP) begin
                  res_status_in = tok_end.hit ? ST_OK : ST_MISS;
                  res_net_in    = tok_end.hit ? tok_end.net : '0;
                  res_mask_in   = tok_end.hit ? tok_end.mask : '0;
               end else if (tok_end.hit) begin
                  res_status_in = ST_PRESENT;
                  res_net_in    = net_ff;
                  res_mask_in   = mask_ff;
               end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                  res_status_in = ST_FULL;
                  res_net_in    = '0;
                  res_mask_in   = '0;
               end else begin
                  res_status_in = ST_OK;
                  res_net_in    = net_ff;
                  res_mask_in   = mask_ff;
                  state_in      = CS_INSERT;
               end
            end
         end
         CS_INSERT: begin
            count_in = count_ff + CNT_W'(1);
            state_in = CS_RESP;
         end
         CS_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_net_in    = res_net_ff;
               rsp_mask_in   = res_mask_ff;
               rsp_count_in  = OUT_COUNT_W'(count_ff);
               state_in      = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         count_ff     <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      addr_ff       <= addr_in;
      net_ff        <= net_in;
      mask_ff       <= mask_in;
      res_status_ff <= res_status_in;
      res_net_ff    <= res_net_in;
      res_mask_ff   <= res_mask_in;
      rsp_status_ff <= rsp_status_in;
      rsp_net_ff    <= rsp_net_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_matched_net  = rsp_net_ff;
   assign rsp_matched_mask = rsp_mask_ff;
   assign rsp_entry_count  = rsp_count_ff;

   // The route count never exceeds the number of cells.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("route count beyond table depth");

   // Every insertion adds exactly one route.
   a_insert_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_INSERT) |=> (count_ff == CNT_W'($past(count_ff) + CNT_W'(1))))
      else $error("insertion did not advance the route count by one");

   // A token only leaves the row while the controller waits for it.
   a_token_scan : assert property (@(posedge clock) disable iff (reset)
      tok_end.active |-> (state_ff == CS_SCAN))
      else $error("search token left the row outside a scan");

   // With the table in mask order the shift flags form a single step, so the
   // new route lands in exactly one cell.
   a_shift_step : assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_INSERT) |->
         $onehot0(ge_vec ^ {ge_vec[TABLE_DEPTH-2:0], 1'b0}))
      else $error("shift flags are not monotonic along the row");

endmodule

// File: rtl/lprt_cell.sv
// ----------------------------------------------------------------------------
// Route table cell
// Holds one route, matches the passing search token against it and takes
// part in the parallel shift that opens a slot for a new route.
// ----------------------------------------------------------------------------
module lprt_cell
   import lprt_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int IDX   = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [$clog2(DEPTH+1)-1:0]         count_i,
   input  cmd_type                            cmd,
   input  tok_type                            tok_in,
   output tok_type                            tok_out,
   input  logic                               prev_ge,
   input  logic [ROUTE_W-1:0]                 prev_net,
   input  logic [ROUTE_W-1:0]                 prev_mask,
   output logic                               ge_out,
   output logic [ROUTE_W-1:0]                 net_out,
   output logic [ROUTE_W-1:0]                 mask_out
);

   localparam int CNT_W = $clog2(DEPTH+1);

   logic [ROUTE_W-1:0] net_ff, net_in;
   logic [ROUTE_W-1:0] mask_ff, mask_in;
   tok_type            tok_ff, tok_in_next;
   logic               vld;
   logic               match;
   logic               hit_here;

   // The entry is in use when its position lies below the route count.
   assign vld = (CNT_W'(IDX) < count_i);

   always_comb begin
      if (cmd.is_add) begin
         match = (net_ff == cmd.net) && (mask_ff == cmd.mask);
      end else begin
         match = ((cmd.addr & mask_ff) == net_ff);
      end
      hit_here = vld & match;

      tok_in_next        = tok_in;
      tok_in_next.hit    = tok_in.hit | (tok_in.active & hit_here);
      if (tok_in.active && !tok_in.hit && hit_here) begin
         tok_in_next.net  = net_ff;
         tok_in_next.mask = mask_ff;
      end

      // Unused cells always take part in the shift, so the flags along the
      // row form a single step from zero to one.
      ge_out  = !vld || (cmd.mask >= mask_ff);

      net_in  = net_ff;
      mask_in = mask_ff;
      if (cmd.insert && ge_out) begin
         if (prev_ge) begin
            net_in  = prev_net;
            mask_in = prev_mask;
         end else begin
            net_in  = cmd.net;
            mask_in = cmd.mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      net_ff  <= net_in;
      mask_ff <= mask_in;
   end

   assign tok_out  = tok_ff;
   assign net_out  = net_ff;
   assign mask_out = mask_ff;

endmodule
